@@ rtl/core/source_token_scanner_assert.svh @@
// assertion macros used by the checker file of the source token scanner
// depends on nothing; the user supplies clock, reset and property
`ifndef SOURCE_TOKEN_SCANNER_ASSERT_SVH
`define SOURCE_TOKEN_SCANNER_ASSERT_SVH

// checked only while reset is released
`define STS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define STS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/sts_pkg.sv @@
// shared types, constants and the punctuator lookup function of the source token scanner
// no dependencies
`timescale 1ns / 1ps

package sts_pkg;

    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int KEYWORD_CHARS_DEFAULT = 6;
    localparam int OUT_W                 = 32;
    localparam int KIND_W                = 5;
    localparam int QUEUE_DEPTH           = 4;
    localparam int KEYWORD_COUNT         = 6;
    localparam int KEYWORD_MAX_CHARS     = 6;
    localparam int IN_DATA_W             = 8;
    localparam int OUT_DATA_W            = 136;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_NUMBER        = 5'd13;
    localparam logic [KIND_W-1:0] KIND_NAME          = 5'd14;
    localparam logic [KIND_W-1:0] KIND_FIRST_KEYWORD = 5'd15;
    localparam logic [KIND_W-1:0] KIND_EOF           = 5'd21;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN       = 5'd22;

    // tuser codes on the input side
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_NAME,
        MODE_HASH,
        MODE_LINE_COMMENT,
        MODE_BLOCK,
        MODE_BLOCK_HASH,
        MODE_HALT
    } sts_mode_t;

    // keyword text, right aligned, in kind order
    localparam logic [8*KEYWORD_MAX_CHARS-1:0] KW_VALUE [KEYWORD_COUNT] = '{
        48'("var"), 48'("val"), 48'("struct"), 48'("fun"), 48'("print"), 48'("return")
    };
    localparam int KW_LEN [KEYWORD_COUNT] = '{3, 3, 6, 3, 5, 6};

    // one result beat
    typedef struct packed {
        logic              last;
        logic [OUT_W-1:0]  column;
        logic [OUT_W-1:0]  line;
        logic [OUT_W-1:0]  length;
        logic [OUT_W-1:0]  start;
        logic [KIND_W-1:0] kind;
    } sts_beat_t;

    // punctuator lookup: bit 5 set when the byte is one, low bits give the kind
    function automatic logic [KIND_W:0] punct_lookup(input logic [7:0] c);
        logic [KIND_W:0] r;
        r = '0;
        case (c)
            8'h28:   r = {1'b1, 5'd0};   // (
            8'h29:   r = {1'b1, 5'd1};   // )
            8'h7B:   r = {1'b1, 5'd2};   // {
            8'h7D:   r = {1'b1, 5'd3};   // }
            8'h2E:   r = {1'b1, 5'd4};   // .
            8'h2C:   r = {1'b1, 5'd5};   // ,
            8'h3B:   r = {1'b1, 5'd6};   // ;
            8'h3A:   r = {1'b1, 5'd7};   // :
            8'h2D:   r = {1'b1, 5'd8};   // -
            8'h2B:   r = {1'b1, 5'd9};   // +
            8'h2A:   r = {1'b1, 5'd10};  // *
            8'h2F:   r = {1'b1, 5'd11};  // /
            8'h3D:   r = {1'b1, 5'd12};  // =
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/sts_result_queue.sv @@
// small result queue: up to two beats pushed per cycle, one popped
// depends on sts_pkg (beat type, depth)
`timescale 1ns / 1ps

module sts_result_queue #(
    parameter int DEPTH = sts_pkg::QUEUE_DEPTH   // power of two, at least 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_count,
    input  sts_pkg::sts_beat_t push_beat [2],
    output logic              room_for_two,
    output logic              out_valid,
    input  logic              out_ready,
    output sts_pkg::sts_beat_t out_beat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sts_pkg::sts_beat_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign out_valid    = (count_reg != '0);
    assign out_beat     = entry_reg[rd_ptr_reg];
    assign room_for_two = (count_reg <= CNT_W'(DEPTH - 2));
    assign pop          = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push_beat[0];
        end
        if (push_count == 2'd2) begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push_beat[1];
        end
    end

endmodule

@@ rtl/core/source_token_scanner.sv @@
// top level of the source token scanner: lexer state and per-byte token logic
// depends on sts_pkg and sts_result_queue
`timescale 1ns / 1ps

// Streaming lexer. One source byte (tuser = 0) or an end-of-source mark
// (tuser = 1) enters per beat and is scanned in the cycle it is accepted:
// the lexer state registers and a four-entry result queue are updated at
// that edge, so a token beat can appear on the master side the cycle after
// the byte that ends it. Each input beat gives zero, one or two result beats
// (a closed number or name followed by the token the byte itself starts);
// tlast marks the final result beat of an input beat. s_tready depends only
// on the queue having two free entries, so with the output side taking beats
// the scanner runs at one byte per cycle; the single output port (one beat a
// cycle) is the only thing that slows it, when bytes give two results each.
// After an unknown byte or the end mark the scanner halts, still accepting
// beats but giving no results, until reset. Positions, line and column
// counters are POSITION_BITS wide and saturate; output fields are the low 32
// bits. Only names of up to KEYWORD_CHARS bytes are checked against keywords.
module source_token_scanner #(
    parameter int POSITION_BITS = sts_pkg::POSITION_BITS_DEFAULT,  // 16 to 64
    parameter int KEYWORD_CHARS = sts_pkg::KEYWORD_CHARS_DEFAULT   // 6 to 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input beats
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sts_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] char_code
    input  logic                           s_tuser,   // [0] operation
    // result beats
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sts_pkg::OUT_DATA_W-1:0] m_tdata,   // [4:0] token_kind, [36:5] start_index,
                                                      // [68:37] token_length,
                                                      // [100:69] line_number,
                                                      // [132:101] column, [135:133] zero
    output logic                           m_tlast    // last_of_run
);

    localparam int PB     = POSITION_BITS;
    localparam int WIN_W  = 8 * KEYWORD_CHARS;
    localparam int FILL_W = $clog2(KEYWORD_CHARS + 1);
    localparam logic [PB-1:0] POS_MAX = '1;

    // lexer state
    sts_pkg::sts_mode_t mode_reg, mode_next;
    logic [PB-1:0]     pos_reg, pos_next;
    logic [PB-1:0]     tok_start_reg, tok_start_next;
    logic [PB-1:0]     line_reg, line_next;
    logic [PB-1:0]     line_begin_reg, line_begin_next;
    logic [PB-1:0]     start_line_reg, start_line_next;
    logic [PB-1:0]     start_col_reg, start_col_next;
    logic [WIN_W-1:0]  window_reg, window_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              overflow_reg, overflow_next;

    // per-beat results
    sts_pkg::sts_beat_t res [2];
    logic [1:0]         res_count;
    logic [1:0]         push_count;
    logic               accept;
    logic               room_for_two;
    sts_pkg::sts_beat_t out_beat;

    // byte classes
    logic [7:0]             c;
    logic                   is_decimal, is_letter, is_op, is_blank, is_newline, is_hash;
    logic [sts_pkg::KIND_W:0] punct;
    logic [PB-1:0]          col_now, tok_len;
    logic [sts_pkg::KIND_W-1:0] name_kind;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = room_for_two;
    assign c        = s_tdata;

    assign is_decimal = (c >= 8'h30) && (c <= 8'h39);
    assign is_letter  = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    assign is_op      = (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h2F);
    assign is_blank   = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D);
    assign is_newline = (c == 8'h0A);
    assign is_hash    = (c == 8'h23);
    assign punct      = sts_pkg::punct_lookup(c);

    // column of the current byte and length of the open token ending here
    assign col_now = (pos_reg >= line_begin_reg) ? pos_reg - line_begin_reg : '0;
    assign tok_len = (pos_reg >= tok_start_reg) ? pos_reg - tok_start_reg : '0;

    // keyword match on the collected name window
    always_comb begin
        name_kind = sts_pkg::KIND_NAME;
        if (!overflow_reg) begin
            for (int k = 0; k < sts_pkg::KEYWORD_COUNT; k++) begin
                if ((fill_reg == FILL_W'(sts_pkg::KW_LEN[k]))
                        && (window_reg == WIN_W'(sts_pkg::KW_VALUE[k]))) begin
                    name_kind = sts_pkg::KIND_FIRST_KEYWORD + sts_pkg::KIND_W'(k);
                end
            end
        end
    end

    function automatic sts_pkg::sts_beat_t make_beat(
        input logic [sts_pkg::KIND_W-1:0] kind,
        input logic [PB-1:0] start,
        input logic [PB-1:0] len,
        input logic [PB-1:0] line,
        input logic [PB-1:0] col
    );
        sts_pkg::sts_beat_t b;
        b.last   = 1'b0;
        b.kind   = kind;
        b.start  = sts_pkg::OUT_W'(start);
        b.length = sts_pkg::OUT_W'(len);
        b.line   = sts_pkg::OUT_W'(line);
        b.column = sts_pkg::OUT_W'(col);
        return b;
    endfunction

    function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
        return (v == POS_MAX) ? v : v + PB'(1);
    endfunction

    // scanner: next state and results for the beat at the port
    always_comb begin
        logic open_tok;
        logic do_idle;
        mode_next       = mode_reg;
        pos_next        = pos_reg;
        tok_start_next  = tok_start_reg;
        line_next       = line_reg;
        line_begin_next = line_begin_reg;
        start_line_next = start_line_reg;
        start_col_next  = start_col_reg;
        window_next     = window_reg;
        fill_next       = fill_reg;
        overflow_next   = overflow_reg;
        res[0]          = '0;
        res[1]          = '0;
        res_count       = 2'd0;
        open_tok        = (mode_reg == sts_pkg::MODE_NUMBER) || (mode_reg == sts_pkg::MODE_NAME);
        do_idle         = 1'b0;

        if (mode_reg == sts_pkg::MODE_HALT) begin
            // halted: beats are swallowed
        end else if (s_tuser == sts_pkg::OP_END) begin
            // close the open token, then end of file at the current position
            if (open_tok) begin
                res[res_count[0]] = make_beat(
                    (mode_reg == sts_pkg::MODE_NUMBER) ? sts_pkg::KIND_NUMBER : name_kind,
                    tok_start_reg, tok_len, start_line_reg, start_col_reg);
                res_count = res_count + 2'd1;
            end
            res[res_count[0]] = make_beat(sts_pkg::KIND_EOF, pos_reg, '0, line_reg, col_now);
            res_count = res_count + 2'd1;
            mode_next = sts_pkg::MODE_HALT;
        end else begin
            pos_next = sat_inc(pos_reg);
            case (mode_reg)
                sts_pkg::MODE_NUMBER: begin
                    do_idle = !is_decimal;
                end
                sts_pkg::MODE_NAME: begin
                    if (is_letter || is_decimal || is_op) begin
                        if (fill_reg >= FILL_W'(KEYWORD_CHARS)) begin
                            overflow_next = 1'b1;
                        end else begin
                            window_next = {window_reg[WIN_W-9:0], c};
                            fill_next   = fill_reg + FILL_W'(1);
                        end
                    end else begin
                        do_idle = 1'b1;
                    end
                end
                sts_pkg::MODE_HASH: begin
                    if (is_hash) begin
                        mode_next = sts_pkg::MODE_BLOCK;
                    end else if (is_newline) begin
                        mode_next       = sts_pkg::MODE_IDLE;
                        line_next       = sat_inc(line_reg);
                        line_begin_next = sat_inc(pos_reg);
                    end else begin
                        mode_next = sts_pkg::MODE_LINE_COMMENT;
                    end
                end
                sts_pkg::MODE_LINE_COMMENT: begin
                    if (is_newline) begin
                        mode_next       = sts_pkg::MODE_IDLE;
                        line_next       = sat_inc(line_reg);
                        line_begin_next = sat_inc(pos_reg);
                    end
                end
                sts_pkg::MODE_BLOCK: begin
                    if (is_hash) begin
                        mode_next = sts_pkg::MODE_BLOCK_HASH;
                    end else if (is_newline) begin
                        line_next       = sat_inc(line_reg);
                        line_begin_next = sat_inc(pos_reg);
                    end
                end
                sts_pkg::MODE_BLOCK_HASH: begin
                    if (is_hash) begin
                        mode_next = sts_pkg::MODE_IDLE;
                    end else begin
                        mode_next = sts_pkg::MODE_BLOCK;
                        if (is_newline) begin
                            line_next       = sat_inc(line_reg);
                            line_begin_next = sat_inc(pos_reg);
                        end
                    end
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase

            if (do_idle) begin
                // a number or name ends just before this byte
                if (open_tok) begin
                    res[0] = make_beat(
                        (mode_reg == sts_pkg::MODE_NUMBER) ? sts_pkg::KIND_NUMBER : name_kind,
                        tok_start_reg, tok_len, start_line_reg, start_col_reg);
                    res_count = 2'd1;
                end
                mode_next = sts_pkg::MODE_IDLE;
                if (is_blank) begin
                    // skipped
                end else if (is_newline) begin
                    line_next       = sat_inc(line_reg);
                    line_begin_next = sat_inc(pos_reg);
                end else if (punct[sts_pkg::KIND_W]) begin
                    res[res_count[0]] = make_beat(punct[sts_pkg::KIND_W-1:0], pos_reg,
                                                  PB'(1), line_reg, col_now);
                    res_count = res_count + 2'd1;
                end else if (is_hash) begin
                    mode_next = sts_pkg::MODE_HASH;
                end else if (is_decimal) begin
                    tok_start_next  = pos_reg;
                    start_line_next = line_reg;
                    start_col_next  = col_now;
                    mode_next       = sts_pkg::MODE_NUMBER;
                end else if (is_letter) begin
                    tok_start_next  = pos_reg;
                    start_line_next = line_reg;
                    start_col_next  = col_now;
                    window_next     = WIN_W'(c);
                    fill_next       = FILL_W'(1);
                    overflow_next   = 1'b0;
                    mode_next       = sts_pkg::MODE_NAME;
                end else begin
                    // unknown byte: report and halt
                    res[res_count[0]] = make_beat(sts_pkg::KIND_UNKNOWN, pos_reg,
                                                  PB'(1), line_reg, col_now);
                    res_count = res_count + 2'd1;
                    mode_next = sts_pkg::MODE_HALT;
                end
            end
        end

        // flag the final beat of this input beat
        if (res_count == 2'd1) begin
            res[0].last = 1'b1;
        end else if (res_count == 2'd2) begin
            res[1].last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= sts_pkg::MODE_IDLE;
            pos_reg        <= '0;
            tok_start_reg  <= '0;
            line_reg       <= PB'(1);
            line_begin_reg <= '0;
            start_line_reg <= PB'(1);
            start_col_reg  <= '0;
            window_reg     <= '0;
            fill_reg       <= '0;
            overflow_reg   <= 1'b0;
        end else if (accept) begin
            mode_reg       <= mode_next;
            pos_reg        <= pos_next;
            tok_start_reg  <= tok_start_next;
            line_reg       <= line_next;
            line_begin_reg <= line_begin_next;
            start_line_reg <= start_line_next;
            start_col_reg  <= start_col_next;
            window_reg     <= window_next;
            fill_reg       <= fill_next;
            overflow_reg   <= overflow_next;
        end
    end

    assign push_count = accept ? res_count : 2'd0;

    // result queue decouples the master side from the scanner
    sts_result_queue #(
        .DEPTH(sts_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_count  (push_count),
        .push_beat   (res),
        .room_for_two(room_for_two),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_beat    (out_beat)
    );

    assign m_tdata = {3'b000, out_beat.column, out_beat.line, out_beat.length,
                      out_beat.start, out_beat.kind};
    assign m_tlast = out_beat.last;

endmodule

@@ rtl/core/sts_checker.sv @@
// port-level checks on the result side of the source token scanner, bound to the top
// depends on sts_pkg and source_token_scanner_assert.svh
`timescale 1ns / 1ps
`include "source_token_scanner_assert.svh"

module sts_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sts_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    // a stalled result beat holds
    `STS_ASSERT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result beat changed while stalled")

    // end of file always closes the run of its input beat
    `STS_ASSERT(a_eof_last, aclk, aresetn, m_tvalid && (m_tdata[4:0] == sts_pkg::KIND_EOF) |-> m_tlast, "end of file beat without tlast")

    // end of file has zero length
    `STS_ASSERT(a_eof_len, aclk, aresetn, m_tvalid && (m_tdata[4:0] == sts_pkg::KIND_EOF) |-> (m_tdata[68:37] == '0), "end of file beat with nonzero length")

    // no kind beyond unknown character
    `STS_ASSERT(a_kind_range, aclk, aresetn, m_tvalid |-> (m_tdata[4:0] <= sts_pkg::KIND_UNKNOWN), "token kind out of range")

    // queue is empty right after reset
    `STS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule

bind source_token_scanner sts_checker u_sts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
